@@ rtl/vlfs_pkg.sv @@
`timescale 1ns / 1ps
// Package for the varint length frame splitter.
// Holds the framing constants, byte kind and parse phase codes and the result type.
// No dependencies.
package vlfs_pkg;

    localparam int LENGTH_BITS         = 32;
    localparam int CONTROL_FRAME_BYTES = 3;
    localparam int MAX_HEADER_BYTES    = (LENGTH_BITS + 6) / 7;
    localparam int HDR_CNT_W           = $clog2(MAX_HEADER_BYTES + 1);

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int PLEN_W    = 32;
    localparam int HLEN_W    = 3;
    localparam int NEED_W    = 32;

    localparam logic [BYTE_W-1:0] VALUE_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] MORE_FLAG  = 8'h80;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONTROL = 2'd2;

    localparam logic [1:0] PHASE_HEADER  = 2'd0;
    localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
    localparam logic [1:0] PHASE_CONTROL = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [KIND_W-1:0] byte_kind;
        logic              frame_first;
        logic              frame_last;
        logic [PLEN_W-1:0] payload_length;
        logic [HLEN_W-1:0] header_length;
        logic [NEED_W-1:0] bytes_needed;
        logic              length_error;
    } t_result;

endpackage

@@ rtl/vlfs_byte_if.sv @@
`timescale 1ns / 1ps
// Byte stream channel: valid, ready and one raw stream byte.
// Depends on vlfs_pkg for the byte width.
interface vlfs_byte_if;
    logic                        valid;
    logic                        ready;
    logic [vlfs_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/vlfs_frame_if.sv @@
`timescale 1ns / 1ps
// Tagged byte channel: valid, ready and the per-byte framing result.
// Depends on vlfs_pkg for the field widths.
interface vlfs_frame_if;
    logic                        valid;
    logic                        ready;
    logic [vlfs_pkg::BYTE_W-1:0] byte_out;
    logic [vlfs_pkg::KIND_W-1:0] byte_kind;
    logic                        frame_first;
    logic                        frame_last;
    logic [vlfs_pkg::PLEN_W-1:0] payload_length;
    logic [vlfs_pkg::HLEN_W-1:0] header_length;
    logic [vlfs_pkg::NEED_W-1:0] bytes_needed;
    logic                        length_error;

    modport source (output valid, output byte_out, output byte_kind, output frame_first,
                    output frame_last, output payload_length, output header_length,
                    output bytes_needed, output length_error, input ready);
    modport sink   (input valid, input byte_out, input byte_kind, input frame_first,
                    input frame_last, input payload_length, input header_length,
                    input bytes_needed, input length_error, output ready);
endinterface

@@ rtl/vlfs_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel: valid, ready and the stream compression bit.
// No dependencies.
interface vlfs_cfg_if;
    logic valid;
    logic ready;
    logic stream_compressed;

    modport source (output valid, output stream_compressed, input ready);
    modport sink   (input valid, input stream_compressed, output ready);
endinterface

@@ rtl/vlfs_parser.sv @@
`timescale 1ns / 1ps
// Frame parser: holds the parse state and the compression setting, and works out
// the tagged result for one byte. Depends on vlfs_pkg.
module vlfs_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_data,
    input  logic                        i_fire,
    input  logic [vlfs_pkg::BYTE_W-1:0] i_data_byte,
    output vlfs_pkg::t_result           o_res
);
    import vlfs_pkg::*;

    logic                   r_compressed;
    logic [1:0]             r_phase,  n_phase;
    logic [LENGTH_BITS-1:0] r_acc,    n_acc;
    logic [HDR_CNT_W-1:0]   r_hc,     n_hc;
    logic [LENGTH_BITS-1:0] r_left,   n_left;

    logic [LENGTH_BITS-1:0] acc_shift;
    logic [LENGTH_BITS-1:0] left_dec;
    logic [HDR_CNT_W-1:0]   hc_inc;
    logic                   overflow;

    function automatic logic [NEED_W-1:0] needed_view(input logic [LENGTH_BITS-1:0] left,
                                                      input logic compressed);
        logic [NEED_W-1:0] v;
        if (left == '0) begin
            v = '0;
        end else if (compressed) begin
            v = NEED_W'(1);
        end else begin
            v = NEED_W'(left);
        end
        return v;
    endfunction

    assign acc_shift = {r_acc[LENGTH_BITS-8:0], i_data_byte[6:0] & VALUE_MASK[6:0]};
    assign hc_inc    = r_hc + HDR_CNT_W'(1);
    assign left_dec  = r_left - LENGTH_BITS'(1);
    assign overflow  = (|r_acc[LENGTH_BITS-1:LENGTH_BITS-7]) ||
                       (r_hc >= HDR_CNT_W'(MAX_HEADER_BYTES));

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_hc    = r_hc;
        n_left  = r_left;

        o_res                = '0;
        o_res.byte_out       = i_data_byte;
        o_res.byte_kind      = KIND_HEADER;

        if (r_phase == PHASE_HEADER) begin
            o_res.frame_first = (r_hc == '0);
            if (overflow) begin
                o_res.length_error = 1'b1;
                o_res.bytes_needed = NEED_W'(1);
                n_phase = PHASE_HEADER;
                n_acc   = '0;
                n_hc    = '0;
                n_left  = '0;
            end else begin
                n_acc = acc_shift;
                n_hc  = hc_inc;
                if ((i_data_byte & MORE_FLAG) != '0) begin
                    o_res.bytes_needed = NEED_W'(1);
                end else if (acc_shift == '0) begin
                    if (32'(hc_inc) >= 32'(CONTROL_FRAME_BYTES)) begin
                        // zero-length header already as long as a control frame
                        o_res.frame_last = 1'b1;
                        n_phase = PHASE_HEADER;
                        n_acc   = '0;
                        n_hc    = '0;
                        n_left  = '0;
                    end else begin
                        n_left  = LENGTH_BITS'(CONTROL_FRAME_BYTES) - LENGTH_BITS'(hc_inc);
                        n_phase = PHASE_CONTROL;
                        o_res.bytes_needed = needed_view(n_left, r_compressed);
                    end
                end else begin
                    n_left  = acc_shift;
                    n_phase = PHASE_PAYLOAD;
                    o_res.bytes_needed = needed_view(acc_shift, r_compressed);
                end
            end
        end else begin
            o_res.byte_kind = (r_phase == PHASE_PAYLOAD) ? KIND_PAYLOAD : KIND_CONTROL;
            if (left_dec == '0) begin
                o_res.frame_last = 1'b1;
                if (r_phase == PHASE_PAYLOAD) begin
                    o_res.payload_length = PLEN_W'(r_acc);
                    o_res.header_length  = HLEN_W'(r_hc);
                end
                n_phase = PHASE_HEADER;
                n_acc   = '0;
                n_hc    = '0;
                n_left  = '0;
            end else begin
                n_left = left_dec;
                o_res.bytes_needed = needed_view(left_dec, r_compressed);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed <= 1'b0;
            r_phase      <= PHASE_HEADER;
            r_acc        <= '0;
            r_hc         <= '0;
            r_left       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_compressed <= i_cfg_data;
            end
            if (i_fire) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_hc    <= n_hc;
                r_left  <= n_left;
            end
        end
    end

endmodule

@@ rtl/varint_length_frame_splitter.sv @@
`timescale 1ns / 1ps
// Varint length frame splitter, top level: input byte register, parser, result register.
// Depends on vlfs_pkg, vlfs_byte_if, vlfs_frame_if, vlfs_cfg_if and vlfs_parser.
//
// Splits a byte stream into frames with big-endian base-128 length headers and tags
// every byte with its kind, frame start and frame end. One byte is taken per clock
// cycle while the output is not stalled; each byte passes through the input register,
// then the result register, and the parse state is updated as it moves between them.
// Both registers advance whenever the stage after them is free or being drained, so
// a full rate stream passes with no gaps. Configuration writes are always ready.
module varint_length_frame_splitter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vlfs_byte_if.sink    i_in,
    vlfs_cfg_if.sink     i_cfg,
    vlfs_frame_if.source o_out
);
    import vlfs_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           res;
    logic              out_free;
    logic              advance;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    vlfs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.stream_compressed),
        .i_fire      (advance),
        .i_data_byte (r_in_byte),
        .o_res       (res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
        end
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.byte_out       = r_out.byte_out;
    assign o_out.byte_kind      = r_out.byte_kind;
    assign o_out.frame_first    = r_out.frame_first;
    assign o_out.frame_last     = r_out.frame_last;
    assign o_out.payload_length = r_out.payload_length;
    assign o_out.header_length  = r_out.header_length;
    assign o_out.bytes_needed   = r_out.bytes_needed;
    assign o_out.length_error   = r_out.length_error;

endmodule

@@ tb/varint_length_frame_splitter_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for varint_length_frame_splitter: directed rows, random traffic, directed rows.
// Depends on vlfs_pkg, vlfs_byte_if, vlfs_cfg_if, vlfs_frame_if and the RTL top level.
module varint_length_frame_splitter_tb;
    import vlfs_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0] din;
        bit                typed;
        t_result           res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    vlfs_byte_if  in_if ();
    vlfs_cfg_if   cfg_if ();
    vlfs_frame_if out_if ();

    varint_length_frame_splitter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Parser mirror
    logic              comp_mode;
    logic [1:0]        parse_phase;
    logic [31:0]       len_acc;
    logic [HLEN_W-1:0] hdr_cnt;
    logic [32:0]       parse_left;
    bit                last_err;

    t_result     expected_tags[$];
    t_row        stim_rows[$];
    int          tail_start;
    int          fail_cnt;
    int          checked_cnt;
    int          bytes_sent;
    int          frames_closed;
    int          len_errors;
    int          burst_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d tags still outstanding", expected_tags.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [NEED_W-1:0] need_view(logic [32:0] cnt);
        if (cnt == 0) return '0;
        if (comp_mode) return 1;
        return (cnt > 33'hffff_ffff) ? '1 : cnt[31:0];
    endfunction

    function automatic void clear_parse();
        parse_phase = PHASE_HEADER;
        len_acc     = '0;
        hdr_cnt     = '0;
        parse_left  = '0;
    endfunction

    // Work out the tags of one byte and advance the parser mirror
    function automatic t_result tag_byte(logic [BYTE_W-1:0] b);
        t_result r;
        r          = '0;
        r.byte_out = b;
        if (parse_phase == PHASE_HEADER) begin
            r.frame_first = (hdr_cnt == 0);
            if ((len_acc >> (LENGTH_BITS - 7)) != 0 || hdr_cnt >= MAX_HEADER_BYTES) begin
                r.length_error = 1'b1;
                r.bytes_needed = 1;
                clear_parse();
            end else begin
                len_acc = (len_acc << 7) | 32'(b & VALUE_MASK);
                hdr_cnt = hdr_cnt + 1'b1;
                if ((b & MORE_FLAG) != 0) begin
                    r.bytes_needed = 1;
                end else if (len_acc == 0) begin
                    // zero length: control frame, possibly complete within its header
                    if (hdr_cnt >= CONTROL_FRAME_BYTES) begin
                        r.frame_last = 1'b1;
                        clear_parse();
                    end else begin
                        parse_left     = 33'(CONTROL_FRAME_BYTES) - 33'(hdr_cnt);
                        parse_phase    = PHASE_CONTROL;
                        r.bytes_needed = need_view(parse_left);
                    end
                end else begin
                    parse_left     = {1'b0, len_acc};
                    parse_phase    = PHASE_PAYLOAD;
                    r.bytes_needed = need_view(parse_left);
                end
            end
        end else begin
            r.byte_kind = (parse_phase == PHASE_PAYLOAD) ? KIND_PAYLOAD : KIND_CONTROL;
            if (parse_left > 0) parse_left = parse_left - 1'b1;
            if (parse_left == 0) begin
                r.frame_last = 1'b1;
                if (parse_phase == PHASE_PAYLOAD) begin
                    r.payload_length = len_acc;
                    r.header_length  = hdr_cnt;
                end
                clear_parse();
            end else begin
                r.bytes_needed = need_view(parse_left);
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    function automatic void add_row(logic [BYTE_W-1:0] b);
        t_row row;
        row.din   = b;
        row.typed = 1'b0;
        row.res   = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_typed(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] kind,
                                      logic first, logic last, logic [PLEN_W-1:0] plen,
                                      logic [HLEN_W-1:0] hlen, logic [NEED_W-1:0] need,
                                      logic err);
        t_row row;
        row.din                = b;
        row.typed              = 1'b1;
        row.res.byte_out       = b;
        row.res.byte_kind      = kind;
        row.res.frame_first    = first;
        row.res.frame_last     = last;
        row.res.payload_length = plen;
        row.res.header_length  = hlen;
        row.res.bytes_needed   = need;
        row.res.length_error   = err;
        stim_rows.push_back(row);
    endfunction

    // Offer one byte, holding valid across bursts; gaps may open between bursts
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input t_result res = '0);
        int      gap;
        t_result pred;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        burst_left--;
        bytes_sent++;
        pred     = tag_byte(b);
        last_err = pred.length_error;
        if (pred.frame_last) frames_closed++;
        if (pred.length_error) len_errors++;
        expected_tags.push_back(typed ? res : pred);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_tags.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic mode);
        cfg_if.valid             <= 1'b1;
        cfg_if.stream_compressed <= mode;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        comp_mode = mode;
    endtask

    // Fill out whatever frame is open so the next one starts on a clean header
    task automatic close_open_frame();
        logic [BYTE_W-1:0] b;
        while (parse_phase != PHASE_HEADER || hdr_cnt != 0) begin
            b = 8'($urandom_range(0, 255));
            if (parse_phase == PHASE_HEADER) b = b & 8'h0f;
            send_byte(b);
        end
    endtask

    task automatic make_frame();
        logic [BYTE_W-1:0] b;
        int pick;
        int len;
        int pad;
        int cnt;
        close_open_frame();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 300) : $urandom_range(1, 40);
            pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, (len >= 128) ? 3 : 4) : 0;
            repeat (pad) send_byte(MORE_FLAG);
            if (len >= 128) send_byte(MORE_FLAG | 8'(len >> 7));
            send_byte(8'(len & 'h7f));
            // now and then cut the payload short
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
            repeat (cnt) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 70) begin
            pad = $urandom_range(0, 4);
            repeat (pad) send_byte(MORE_FLAG);
            send_byte(8'h00);
            while (parse_phase == PHASE_CONTROL) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 82) begin
            // keep the header open until it overflows
            last_err = 1'b0;
            while (!last_err) begin
                b = 8'($urandom_range(0, 255));
                if (!((len_acc >> (LENGTH_BITS - 7)) != 0 || hdr_cnt >= MAX_HEADER_BYTES))
                    b = b | MORE_FLAG;
                send_byte(b);
            end
        end else begin
            cnt = $urandom_range(1, 4);
            repeat (cnt) begin
                b = 8'($urandom_range(0, 255));
                // bound the length that loose header bytes can build up
                if (parse_phase == PHASE_HEADER && len_acc != 0) b[7] = 1'b0;
                if (parse_phase == PHASE_HEADER && b[7]) b[6:1] = '0;
                send_byte(b);
            end
        end
    endtask

    // Receiver: rotate a stall pattern, reloaded every so often
    initial begin : receiver
        logic [15:0] pat;
        int          stride;
        out_if.ready <= 1'b0;
        pat    = '1;
        stride = 0;
        forever begin
            @(posedge i_clk);
            if (stride == 0) begin
                stride = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0:       pat = 16'hffff;
                    1:       pat = 16'($urandom);
                    2:       pat = 16'($urandom) & 16'($urandom);
                    default: pat = 16'haaaa;
                endcase
                pat = pat | 16'h0001;
            end
            out_if.ready <= pat[0];
            pat = {pat[0], pat[15:1]};
            stride--;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            checked_cnt++;
            if (expected_tags.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual byte %02h",
                         $time, out_if.byte_out);
                fail_cnt++;
            end else begin
                want = expected_tags.pop_front();
                check_field("byte_out", 32'(want.byte_out), 32'(out_if.byte_out));
                check_field("byte_kind", 32'(want.byte_kind), 32'(out_if.byte_kind));
                check_field("frame_first", 32'(want.frame_first), 32'(out_if.frame_first));
                check_field("frame_last", 32'(want.frame_last), 32'(out_if.frame_last));
                check_field("payload_length", want.payload_length, out_if.payload_length);
                check_field("header_length", 32'(want.header_length),
                            32'(out_if.header_length));
                check_field("bytes_needed", want.bytes_needed, out_if.bytes_needed);
                check_field("length_error", 32'(want.length_error), 32'(out_if.length_error));
            end
        end
    end

    initial begin : stimulus
        int start;
        i_rst_n                  <= 1'b0;
        in_if.valid              <= 1'b0;
        in_if.data_byte          <= '0;
        cfg_if.valid             <= 1'b0;
        cfg_if.stream_compressed <= 1'b0;
        comp_mode     = 1'b0;
        clear_parse();
        last_err      = 1'b0;
        fail_cnt      = 0;
        checked_cnt   = 0;
        bytes_sent    = 0;
        frames_closed = 0;
        len_errors    = 0;
        burst_left    = 0;

        // control frame with a one-byte header
        add_typed(8'h00, KIND_HEADER, 1'b1, 1'b0, '0, '0, 32'd2, 1'b0);
        add_row(8'haa);
        add_typed(8'h55, KIND_CONTROL, 1'b0, 1'b1, '0, '0, '0, 1'b0);
        // control frame closed by its own header
        add_row(8'h80);
        add_row(8'h80);
        add_typed(8'h00, KIND_HEADER, 1'b0, 1'b1, '0, '0, '0, 1'b0);
        // one payload byte
        add_typed(8'h01, KIND_HEADER, 1'b1, 1'b0, '0, '0, 32'd1, 1'b0);
        add_typed(8'hff, KIND_PAYLOAD, 1'b0, 1'b1, 32'd1, 3'd1, '0, 1'b0);
        // padded two-byte header, three payload bytes
        add_row(8'h80);
        add_row(8'h03);
        add_row(8'h00);
        add_row(8'h7f);
        add_typed(8'hff, KIND_PAYLOAD, 1'b0, 1'b1, 32'd3, 3'd2, '0, 1'b0);
        // header value shifted past 32 bits
        add_row(8'h90);
        repeat (3) add_row(8'h80);
        add_typed(8'h80, KIND_HEADER, 1'b0, 1'b0, '0, '0, 32'd1, 1'b1);
        // one header byte too many
        repeat (5) add_row(8'h80);
        add_typed(8'h7f, KIND_HEADER, 1'b0, 1'b0, '0, '0, 32'd1, 1'b1);
        tail_start = stim_rows.size();
        // largest length: five header bytes, then the frame stays open
        add_row(8'h8f);
        repeat (3) add_row(8'hff);
        add_typed(8'h7f, KIND_HEADER, 1'b0, 1'b0, '0, '0, 32'hffff_ffff, 1'b0);
        add_row(8'h00);
        add_row(8'hff);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_cfg(1'b0);
        for (int i = 0; i < tail_start; i++)
            send_byte(stim_rows[i].din, stim_rows[i].typed, stim_rows[i].res);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0:       write_cfg(1'b1);
                1:       write_cfg(1'b0);
                2:       write_cfg(1'($urandom_range(0, 1)));
                default: write_cfg(1'b1);
            endcase
            start = bytes_sent;
            while (bytes_sent - start < 400) make_frame();
        end

        close_open_frame();
        drain();
        write_cfg(1'b0);
        for (int i = tail_start; i < stim_rows.size(); i++)
            send_byte(stim_rows[i].din, stim_rows[i].typed, stim_rows[i].res);
        drain();

        $display("Sent %0d bytes: %0d frames closed, %0d length errors; %0d transfers checked",
                 bytes_sent, frames_closed, len_errors, checked_cnt);
        $display("Compression setting driven both ways, with idle and stall patterns on both sides");
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
